// File: rtl/assert_macros.svh
// shared assertion macros for the sequencer checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every edge outside reset
`define CHK_ALWAYS(lbl, ck, rs, cond, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (cond)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define CHK_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/smbbm_pkg.sv
package smbbm_pkg;

  // fixed field widths
  localparam int ADDR_BITS      = 3;
  localparam int CFG_BITS       = 16;
  localparam int DELAY_BITS     = 16;
  localparam int CNT_BITS       = 2;
  localparam int SRC_BITS       = 2;
  localparam int CFG_INDEX_BITS = 1;

  // item opcodes
  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  // request sources (anything else takes no extra delay)
  localparam logic [SRC_BITS-1:0] SRC_DIRECT = 2'd0;
  localparam logic [SRC_BITS-1:0] SRC_BUTTON = 2'd1;

  // configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_BUTTON_DELAY    = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DISCONNECT_TIME = 1'd1;

  // pending queue fill levels
  localparam logic [CNT_BITS-1:0] CNT_ZERO = 2'd0;
  localparam logic [CNT_BITS-1:0] CNT_ONE  = 2'd1;
  localparam logic [CNT_BITS-1:0] CNT_TWO  = 2'd2;

  localparam logic [DELAY_BITS-1:0] DELAY_MAX = 16'hFFFF;

endpackage

// File: rtl/sim_mux_break_before_make_sequencer_unit.sv
// path: an input transaction passes the input register, then the result register
// throughput: one item per cycle unless stalled; the state update for one item is a
// single pass of compares and adds on registered state, so items follow back to back
// reset: rst is synchronous, active high; clears time counter, mux state,
// pending queue, configuration registers and both valid flags
module sim_mux_break_before_make_sequencer_unit import smbbm_pkg::*; #(
  parameter int SLOT_BITS = 3,
  parameter int TIME_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  // input item channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      opcode,
  input  logic [SRC_BITS-1:0]       request_source,
  input  logic                      req_enabled,
  input  logic [ADDR_BITS-1:0]      req_slot,
  // result channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      host_enable,
  output logic                      path_enable,
  output logic [ADDR_BITS-1:0]      mux_address,
  output logic [CNT_BITS-1:0]       pending_count,
  output logic [CNT_BITS-1:0]       applied_count,
  output logic [DELAY_BITS-1:0]     next_delay,
  // configuration write channel
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]       cfg_data
);

  // slot bits actually kept: the request field has only ADDR_BITS bits
  localparam int SW = (SLOT_BITS < ADDR_BITS) ? SLOT_BITS : ADDR_BITS;
  localparam int TMSB = TIME_BITS - 1;

  // configuration registers
  logic [CFG_BITS-1:0] button_delay;
  logic [CFG_BITS-1:0] disconnect_time;

  // input register stage
  logic                 s1_valid;
  logic                 s1_opcode;
  logic [SRC_BITS-1:0]  s1_source;
  logic                 s1_enabled;
  logic [ADDR_BITS-1:0] s1_slot;
  logic                 s1_advance;

  // sequencer state
  logic [TIME_BITS-1:0] time_now;
  logic                 cur_enabled;
  logic [SW-1:0]        cur_slot;
  logic [TIME_BITS-1:0] cur_stamp;
  logic                 p0_enabled, p1_enabled;
  logic [SW-1:0]        p0_slot, p1_slot;
  logic [TIME_BITS-1:0] p0_stamp, p1_stamp;
  logic [CNT_BITS-1:0]  pend_count;

  logic [TIME_BITS-1:0] time_now_next;
  logic                 cur_enabled_next;
  logic [SW-1:0]        cur_slot_next;
  logic [TIME_BITS-1:0] cur_stamp_next;
  logic                 p0_enabled_next, p1_enabled_next;
  logic [SW-1:0]        p0_slot_next, p1_slot_next;
  logic [TIME_BITS-1:0] p0_stamp_next, p1_stamp_next;
  logic [CNT_BITS-1:0]  pend_count_next;
  logic [CNT_BITS-1:0]  applied_next;
  logic [DELAY_BITS-1:0] delay_next;

  // tick path
  logic [TIME_BITS-1:0] time_inc;
  logic [TIME_BITS-1:0] due_diff0, due_diff1;
  logic                 due0, due1;

  // request path
  logic [SW-1:0]        req_slot_kept;
  logic [TIME_BITS-1:0] start_time;
  logic [TIME_BITS-1:0] min_on_time;
  logic [TIME_BITS-1:0] on_diff;
  logic [TIME_BITS-1:0] disc_ext;

  logic [TIME_BITS-1:0] delay_diff;

  // config writes are taken at any time; the block is idle by contract
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      button_delay    <= '0;
      disconnect_time <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BUTTON_DELAY:    button_delay    <= cfg_data;
        CFG_DISCONNECT_TIME: disconnect_time <= cfg_data;
        default: ;
      endcase
    end
  end

  // the input register moves on whenever the result register can take its item
  assign s1_advance = s1_valid && !(out_valid && out_stall);
  assign in_stall   = s1_valid && out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_opcode  <= opcode;
      s1_source  <= request_source;
      s1_enabled <= req_enabled;
      s1_slot    <= req_slot;
    end
  end

  assign disc_ext      = TIME_BITS'(disconnect_time);
  assign req_slot_kept = s1_slot[SW-1:0];

  // due checks against the advanced time, both slots in parallel
  assign time_inc  = time_now + TIME_BITS'(1);
  assign due_diff0 = time_inc - p0_stamp;
  assign due_diff1 = time_inc - p1_stamp;
  assign due0      = (pend_count != CNT_ZERO) && !due_diff0[TMSB];
  assign due1      = (pend_count == CNT_TWO) && !due_diff1[TMSB];

  // button requests start late; other sources start now
  assign start_time  = (s1_source == SRC_BUTTON) ?
                       time_now + TIME_BITS'(button_delay) : time_now;
  assign min_on_time = cur_stamp + disc_ext;
  assign on_diff     = start_time - min_on_time;

  always_comb begin
    time_now_next    = time_now;
    cur_enabled_next = cur_enabled;
    cur_slot_next    = cur_slot;
    cur_stamp_next   = cur_stamp;
    p0_enabled_next  = p0_enabled;
    p0_slot_next     = p0_slot;
    p0_stamp_next    = p0_stamp;
    p1_enabled_next  = p1_enabled;
    p1_slot_next     = p1_slot;
    p1_stamp_next    = p1_stamp;
    pend_count_next  = pend_count;
    applied_next     = CNT_ZERO;

    if (s1_opcode == OP_TICK) begin
      time_now_next = time_inc;
      if (due0) begin
        // head applies, queue shifts down
        p0_enabled_next = p1_enabled;
        p0_slot_next    = p1_slot;
        p0_stamp_next   = p1_stamp;
        if (due1) begin
          // second entry due on the same tick
          cur_enabled_next = p1_enabled;
          cur_slot_next    = p1_slot;
          cur_stamp_next   = p1_stamp;
          pend_count_next  = CNT_ZERO;
          applied_next     = CNT_TWO;
        end else begin
          cur_enabled_next = p0_enabled;
          cur_slot_next    = p0_slot;
          cur_stamp_next   = p0_stamp;
          pend_count_next  = pend_count - CNT_ONE;
          applied_next     = CNT_ONE;
        end
      end
    end else if (s1_source == SRC_DIRECT) begin
      // direct requests replace the schedule, even off to off
      p0_enabled_next = s1_enabled;
      p0_slot_next    = req_slot_kept;
      p0_stamp_next   = time_now;
      pend_count_next = CNT_ONE;
    end else if (cur_enabled && s1_enabled) begin
      // break before make: off step carrying the new slot, then on
      p0_enabled_next = 1'b0;
      p0_slot_next    = req_slot_kept;
      p0_stamp_next   = start_time;
      p1_enabled_next = 1'b1;
      p1_slot_next    = req_slot_kept;
      p1_stamp_next   = start_time + disc_ext;
      pend_count_next = CNT_TWO;
    end else if (!cur_enabled && s1_enabled) begin
      // turn on no earlier than the minimum off time
      p0_enabled_next = 1'b1;
      p0_slot_next    = req_slot_kept;
      p0_stamp_next   = on_diff[TMSB] ? min_on_time : start_time;
      pend_count_next = CNT_ONE;
    end else if (cur_enabled && !s1_enabled) begin
      p0_enabled_next = 1'b0;
      p0_slot_next    = req_slot_kept;
      p0_stamp_next   = start_time;
      pend_count_next = CNT_ONE;
    end
  end

  // distance to the queue head, clamped at zero and at the field maximum
  assign delay_diff = p0_stamp_next - time_now_next;

  always_comb begin
    if (pend_count_next == CNT_ZERO || delay_diff[TMSB]) begin
      delay_next = '0;
    end else if (delay_diff > TIME_BITS'(DELAY_MAX)) begin
      delay_next = DELAY_MAX;
    end else begin
      delay_next = delay_diff[DELAY_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_now    <= '0;
      cur_enabled <= 1'b0;
      cur_slot    <= '0;
      cur_stamp   <= '0;
      p0_enabled  <= 1'b0;
      p0_slot     <= '0;
      p0_stamp    <= '0;
      p1_enabled  <= 1'b0;
      p1_slot     <= '0;
      p1_stamp    <= '0;
      pend_count  <= CNT_ZERO;
    end else if (s1_advance) begin
      time_now    <= time_now_next;
      cur_enabled <= cur_enabled_next;
      cur_slot    <= cur_slot_next;
      cur_stamp   <= cur_stamp_next;
      p0_enabled  <= p0_enabled_next;
      p0_slot     <= p0_slot_next;
      p0_stamp    <= p0_stamp_next;
      p1_enabled  <= p1_enabled_next;
      p1_slot     <= p1_slot_next;
      p1_stamp    <= p1_stamp_next;
      pend_count  <= pend_count_next;
    end
  end

  // result register: holds while the consumer stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      host_enable   <= cur_enabled_next;
      path_enable   <= cur_enabled_next;
      mux_address   <= ADDR_BITS'(cur_slot_next);
      pending_count <= pend_count_next;
      applied_count <= applied_next;
      next_delay    <= delay_next;
    end
  end

endmodule

// File: rtl/smbbm_checker.sv
`include "assert_macros.svh"

module smbbm_checker import smbbm_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic                  host_enable,
  input logic                  path_enable,
  input logic [CNT_BITS-1:0]   pending_count,
  input logic [CNT_BITS-1:0]   applied_count,
  input logic [DELAY_BITS-1:0] next_delay
);

  // a stalled result stays offered
  `CHK_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid, "result dropped under stall")

  // input side only backs up when the result side is blocked
  `CHK_ALWAYS(a_stall_cause, clk, rst, !in_stall || (out_valid && out_stall), "spurious input stall")

  // both drive groups follow the same enable
  `CHK_ALWAYS(a_enables_match, clk, rst, !out_valid || (host_enable == path_enable), "enable mismatch")

  // queue holds at most two entries and at most two apply per tick
  `CHK_ALWAYS(a_count_range, clk, rst, !out_valid || (pending_count != 2'd3 && applied_count != 2'd3), "count out of range")

  // an empty queue reports no delay
  `CHK_ALWAYS(a_empty_delay, clk, rst, !out_valid || pending_count != CNT_ZERO || next_delay == '0, "delay with empty queue")

endmodule

bind sim_mux_break_before_make_sequencer_unit smbbm_checker u_smbbm_checker (.*);
